// ----- sv/rqmtf_pkg.sv -----
// Shared types and constants for the rotating move-to-front queue.
package rqmtf_pkg;

  localparam int unsigned ID_W = 7;

  localparam logic CMD_SERVE   = 1'b0;
  localparam logic CMD_PROMOTE = 1'b1;

  localparam logic [ID_W-1:0] COUNT_RESET = 7'd64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SERVE,
    S_PROM_FIRST,
    S_PROM_LOOP,
    S_PROM_FRONT
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic cfg_load;
    logic idx_clr;
    logic idx_inc;
    logic carry_ld;
    logic wr_carry;
    logic wr_target;
    logic head_adv;
    logic out_fire;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic target_ok;
  } dp_stat_t;

endpackage

// ----- sv/rqmtf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rqmtf_ram #(
  parameter int unsigned WIDTH = 7,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/rqmtf_datapath.sv -----
// Datapath: circular order store, head and index registers, count and result register.
module rqmtf_datapath #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rqmtf_pkg::dp_cmd_t            cmd,
  output rqmtf_pkg::dp_stat_t           stat,
  input  logic [rqmtf_pkg::ID_W-1:0]    in_target_id,
  input  logic [rqmtf_pkg::ID_W-1:0]    cfg_active_count,
  output logic                          out_valid,
  output logic [rqmtf_pkg::ID_W-1:0]    out_served_id
);
  import rqmtf_pkg::*;

  localparam int unsigned AW      = $clog2(MAX_ENTRIES);
  localparam int unsigned ID_MAX  = (1 << ID_W) - 1;
  localparam int unsigned CAP     = (MAX_ENTRIES < ID_MAX) ? MAX_ENTRIES : ID_MAX;
  localparam logic [ID_W-1:0] CAP_V = ID_W'(CAP);
  localparam logic [ID_W-1:0] RESET_CNT = (COUNT_RESET > CAP_V) ? CAP_V : COUNT_RESET;

  logic [ID_W-1:0]        count_r, count_nxt;
  logic [AW-1:0]          head_r, head_nxt;
  logic [AW-1:0]          idx_r, idx_nxt;
  logic [MAX_ENTRIES-1:0] valid_r, valid_nxt;
  logic [ID_W-1:0]        carry_r, carry_nxt;
  logic [ID_W-1:0]        target_r, target_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]        out_id_r, out_id_nxt;
  logic                   rd_valid_r, rd_valid_nxt;
  logic [ID_W-1:0]        rd_def_r, rd_def_nxt;

  logic [AW:0]            n_ext;
  logic [AW:0]            head_inc;
  logic [AW-1:0]          raddr, waddr;
  logic [AW:0]            raddr_inc;
  logic                   we;
  logic [ID_W-1:0]        wdata;
  logic [ID_W-1:0]        ram_rdata;
  logic [ID_W-1:0]        rd_word;
  logic [ID_W-1:0]        cfg_clamped;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [AW-1:0] idx,
                                         input logic [AW:0]   n);
    logic [AW:0] sum;
    sum = {1'b0, head} + {1'b0, idx};
    if (sum >= n) begin
      sum = sum - n;
    end
    return sum[AW-1:0];
  endfunction

  assign n_ext = (AW+1)'(count_r);

  always_comb begin
    if (cfg_active_count == '0) begin
      cfg_clamped = ID_W'(1);
    end else if (cfg_active_count > CAP_V) begin
      cfg_clamped = CAP_V;
    end else begin
      cfg_clamped = cfg_active_count;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + AW'(1);
    end
  end

  assign raddr     = phys(head_r, idx_nxt, n_ext);
  assign waddr     = phys(head_r, idx_r, n_ext);
  assign we        = cmd.wr_carry | cmd.wr_target;
  assign wdata     = cmd.wr_target ? target_r : carry_r;
  assign raddr_inc = {1'b0, raddr} + (AW+1)'(1);
  assign rd_word   = rd_valid_r ? ram_rdata : rd_def_r;
  assign head_inc  = {1'b0, head_r} + (AW+1)'(1);

  rqmtf_ram #(
    .WIDTH (ID_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    count_nxt     = count_r;
    head_nxt      = head_r;
    valid_nxt     = valid_r;
    carry_nxt     = carry_r;
    target_nxt    = target_r;
    out_valid_nxt = 1'b0;
    out_id_nxt    = out_id_r;
    rd_valid_nxt  = valid_r[raddr];
    rd_def_nxt    = ID_W'(raddr_inc);
    if (cmd.cfg_load) begin
      count_nxt = cfg_clamped;
      head_nxt  = '0;
      valid_nxt = '0;
    end
    if (cmd.accept) begin
      target_nxt = in_target_id;
    end
    if (cmd.carry_ld) begin
      carry_nxt = rd_word;
    end
    if (we) begin
      valid_nxt[waddr] = 1'b1;
    end
    if (cmd.head_adv) begin
      head_nxt = (head_inc == n_ext) ? '0 : head_inc[AW-1:0];
    end
    if (cmd.out_fire) begin
      out_valid_nxt = 1'b1;
      out_id_nxt    = rd_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= RESET_CNT;
      head_r      <= '0;
      idx_r       <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      idx_r       <= idx_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    carry_r    <= carry_nxt;
    target_r   <= target_nxt;
    out_id_r   <= out_id_nxt;
    rd_valid_r <= rd_valid_nxt;
    rd_def_r   <= rd_def_nxt;
  end

  assign stat.hit       = (rd_word == target_r);
  assign stat.target_ok = (in_target_id != '0) && (in_target_id <= count_r);

  assign out_valid     = out_valid_r;
  assign out_served_id = out_id_r;

  a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, head_r} < n_ext)
    else $error("head pointer beyond active count");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, idx_r} < n_ext)
    else $error("scan index beyond active count");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0 && count_r <= CAP_V)
    else $error("active count out of range");

endmodule

// ----- sv/rqmtf_ctrl.sv -----
// Controller state machine that sequences serve and promote commands.
module rqmtf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_cmd,
  input  logic                cfg_valid,
  input  rqmtf_pkg::dp_stat_t stat,
  output rqmtf_pkg::dp_cmd_t  cmd,
  output logic                busy
);
  import rqmtf_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.idx_clr  = 1'b1;
        cmd.accept   = start;
        cmd.cfg_load = cfg_valid;
        if (start) begin
          if (in_cmd == CMD_SERVE) begin
            state_nxt = S_SERVE;
          end else if (stat.target_ok) begin
            state_nxt = S_PROM_FIRST;
          end
        end
      end
      S_SERVE: begin
        cmd.out_fire = 1'b1;
        cmd.head_adv = 1'b1;
        cmd.idx_clr  = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_PROM_FIRST: begin
        if (stat.hit) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.carry_ld = 1'b1;
          cmd.idx_inc  = 1'b1;
          state_nxt    = S_PROM_LOOP;
        end
      end
      S_PROM_LOOP: begin
        cmd.wr_carry = 1'b1;
        cmd.carry_ld = 1'b1;
        if (stat.hit) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_PROM_FRONT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_PROM_FRONT: begin
        cmd.wr_target = 1'b1;
        cmd.idx_clr   = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

  a_front_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PROM_FRONT |=> state_r == S_IDLE)
    else $error("front write not followed by idle");

endmodule

// ----- sv/rotating_queue_move_to_front.sv -----
// Top level of the rotating queue with move-to-front promotion.
// The block keeps an ordered list of identifiers 1..active_count.
// A word is accepted on a clock edge where start is high and busy is low.
// A serve word (in_cmd 0) reports the front identifier on out_served_id with
// out_valid high for one cycle from the result register, and rotates it to
// the back; busy is high in the serve state, which advances the head.
// A promote word (in_cmd 1) moves in_target_id to the front and gives no
// result. It scans the list from the front, one list entry per cycle, through
// the order store memory; an unknown identifier, including 0, is taken
// without a scan.
// The cfg channel writes active_count while the block is idle and reloads
// ascending order at once; cfg_ready is low while busy.
// After reset the list holds 1..64 (capped at MAX_ENTRIES) with no fill pass.
// The receiver of results cannot stall; each result is shown exactly once.
module rotating_queue_move_to_front #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_cmd,
  input  logic [rqmtf_pkg::ID_W-1:0] in_target_id,
  output logic                       out_valid,
  output logic [rqmtf_pkg::ID_W-1:0] out_served_id,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rqmtf_pkg::ID_W-1:0] cfg_active_count
);
  import rqmtf_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic     busy_int;

  rqmtf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_cmd    (in_cmd),
    .cfg_valid (cfg_valid),
    .stat      (dp_stat),
    .cmd       (dp_cmd),
    .busy      (busy_int)
  );

  rqmtf_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (dp_cmd),
    .stat             (dp_stat),
    .in_target_id     (in_target_id),
    .cfg_active_count (cfg_active_count),
    .out_valid        (out_valid),
    .out_served_id    (out_served_id)
  );

  assign busy      = busy_int;
  assign cfg_ready = !busy_int;

  a_result_from_serve: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2) && $past(in_cmd, 2) == CMD_SERVE)
    else $error("result without a serve word two cycles earlier");

endmodule
